/* hw/rtl/slps_pkg.sv */
// Shared types and constants for the status LED pattern sequencer.
// Pattern and color codes, register indexes, payload structs and reset values.
// No dependencies.
`timescale 1ns / 1ps

package slps_pkg;

  // Timer width default and width of a computed step delay (fast period times four)
  localparam int TIMER_BITS_DEF = 16;
  localparam int DELAY_W        = 18;
  localparam int PCT_W          = 7;
  localparam int MS_W           = 16;
  localparam int CFG_IDX_W      = 3;

  // Patterns, in priority order
  typedef enum logic [2:0] {
    PAT_BOOT    = 3'd0,
    PAT_REPLACE = 3'd1,
    PAT_LOW     = 3'd2,
    PAT_HALF    = 3'd3,
    PAT_HOST    = 3'd4,
    PAT_IDLE    = 3'd5
  } pattern_t;

  typedef enum logic [1:0] {
    COL_OFF   = 2'd0,
    COL_BLUE  = 2'd1,
    COL_AMBER = 2'd2,
    COL_GREEN = 2'd3
  } color_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOOT_ON      = 3'd0,
    REG_FAST_BLINK   = 3'd1,
    REG_PULSE        = 3'd2,
    REG_PULSE_GAP    = 3'd3,
    REG_LOW_REST     = 3'd4,
    REG_REPLACE_REST = 3'd5,
    REG_LOW_THR      = 3'd6,
    REG_REPLACE_THR  = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [MS_W-1:0]  BOOT_ON_RST      = 16'd3000;
  localparam logic [MS_W-1:0]  FAST_BLINK_RST   = 16'd250;
  localparam logic [MS_W-1:0]  PULSE_RST        = 16'd120;
  localparam logic [MS_W-1:0]  PULSE_GAP_RST    = 16'd280;
  localparam logic [MS_W-1:0]  LOW_REST_RST     = 16'd30000;
  localparam logic [MS_W-1:0]  REPLACE_REST_RST = 16'd15000;
  localparam logic [PCT_W-1:0] LOW_THR_RST      = 7'd15;
  localparam logic [PCT_W-1:0] REPLACE_THR_RST  = 7'd5;

  // Last-seen status after reset
  localparam logic [PCT_W-1:0] LAST_PCT_RST = 7'd100;

  // Pulse edge counts per battery pattern
  localparam logic [2:0] REPLACE_EDGES = 3'd4;
  localparam logic [2:0] LOW_EDGES     = 3'd2;

  typedef struct packed {
    logic             active;
    logic [PCT_W-1:0] battery_percent;
    logic             host_link_up;
    logic             half_link_up;
  } in_payload_t;

  typedef struct packed {
    logic       led_red;
    logic       led_green;
    logic       led_blue;
    logic [2:0] shown_pattern;
  } out_payload_t;

  typedef struct packed {
    cfg_idx_t        index;
    logic [MS_W-1:0] data;
  } cfg_payload_t;

  // Register file contents as seen by the step logic
  typedef struct packed {
    logic [MS_W-1:0]  boot_solid_ms;
    logic [MS_W-1:0]  blink_half_ms;
    logic [MS_W-1:0]  amber_on_ms;
    logic [MS_W-1:0]  amber_gap_ms;
    logic [MS_W-1:0]  low_rest_ms;
    logic [MS_W-1:0]  replace_rest_ms;
    logic [PCT_W-1:0] low_threshold_pct;
    logic [PCT_W-1:0] replace_threshold_pct;
  } cfg_t;

  // Sequencer state apart from the delay timer
  typedef struct packed {
    pattern_t         shown;
    logic [1:0]       step;
    logic             boot_pending;
    color_t           color;
    logic             last_active;
    logic [PCT_W-1:0] last_pct;
    logic             last_host;
    logic             last_half;
  } seq_state_t;

endpackage

/* hw/rtl/slps_stream_if.sv */
// Valid/ready channel interface used for input, result and configuration transfers.
// Payload type is a parameter; depends on nothing else.
`timescale 1ns / 1ps

interface slps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/slps_cfg_regs.sv */
// Configuration register file of the status LED sequencer.
// Depends on slps_pkg and slps_stream_if.
`timescale 1ns / 1ps

module slps_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  slps_stream_if.sink          cfg_ch,
  output slps_pkg::cfg_t       cfg
);

  slps_pkg::cfg_t cfg_r;
  logic           wr_en;

  // Writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_solid_ms         <= slps_pkg::BOOT_ON_RST;
      cfg_r.blink_half_ms         <= slps_pkg::FAST_BLINK_RST;
      cfg_r.amber_on_ms           <= slps_pkg::PULSE_RST;
      cfg_r.amber_gap_ms          <= slps_pkg::PULSE_GAP_RST;
      cfg_r.low_rest_ms           <= slps_pkg::LOW_REST_RST;
      cfg_r.replace_rest_ms       <= slps_pkg::REPLACE_REST_RST;
      cfg_r.low_threshold_pct     <= slps_pkg::LOW_THR_RST;
      cfg_r.replace_threshold_pct <= slps_pkg::REPLACE_THR_RST;
    end else if (wr_en) begin
      unique case (cfg_ch.payload.index)
        slps_pkg::REG_BOOT_ON:      cfg_r.boot_solid_ms   <= cfg_ch.payload.data;
        slps_pkg::REG_FAST_BLINK:   cfg_r.blink_half_ms   <= cfg_ch.payload.data;
        slps_pkg::REG_PULSE:        cfg_r.amber_on_ms     <= cfg_ch.payload.data;
        slps_pkg::REG_PULSE_GAP:    cfg_r.amber_gap_ms    <= cfg_ch.payload.data;
        slps_pkg::REG_LOW_REST:     cfg_r.low_rest_ms     <= cfg_ch.payload.data;
        slps_pkg::REG_REPLACE_REST: cfg_r.replace_rest_ms <= cfg_ch.payload.data;
        slps_pkg::REG_LOW_THR:
          cfg_r.low_threshold_pct <= cfg_ch.payload.data[slps_pkg::PCT_W-1:0];
        slps_pkg::REG_REPLACE_THR:
          cfg_r.replace_threshold_pct <= cfg_ch.payload.data[slps_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/slps_step_logic.sv */
// Combinational next-state and LED result for one millisecond tick.
// Pattern priority, pattern stepping and delay timer update. Depends on slps_pkg.
`timescale 1ns / 1ps

module slps_step_logic #(
  parameter int TIMER_BITS = slps_pkg::TIMER_BITS_DEF
) (
  input  slps_pkg::cfg_t         cfg,
  input  slps_pkg::in_payload_t  item,
  input  slps_pkg::seq_state_t   cur,
  input  logic [TIMER_BITS-1:0]  delay_cur,
  output slps_pkg::seq_state_t   nxt,
  output logic [TIMER_BITS-1:0]  delay_nxt,
  output slps_pkg::out_payload_t result
);

  localparam int CMP_W = (TIMER_BITS > slps_pkg::DELAY_W) ? TIMER_BITS : slps_pkg::DELAY_W;
  localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'({TIMER_BITS{1'b1}});

  slps_pkg::pattern_t         pick;
  slps_pkg::color_t           blink_col;
  logic                       changed;
  logic                       force_step;
  logic                       run;
  logic [TIMER_BITS-1:0]      delay_dec;
  logic [1:0]                 step_base;
  logic [2:0]                 edges;
  logic [2:0]                 bat_pos;
  logic [2:0]                 bat_pos_inc;
  logic                       bat_on;
  logic [slps_pkg::DELAY_W-1:0] next_delay;
  logic [CMP_W-1:0]           next_ext;

  // Status change detection against the last tick
  assign changed = (item.battery_percent != cur.last_pct) ||
                   (item.host_link_up != cur.last_host) ||
                   (item.half_link_up != cur.last_half);
  assign force_step = !cur.last_active || (changed && !cur.boot_pending);
  assign delay_dec  = delay_cur - TIMER_BITS'(1);

  // Pattern priority
  always_comb begin
    if (cur.boot_pending)
      pick = slps_pkg::PAT_BOOT;
    else if (item.battery_percent <= cfg.replace_threshold_pct)
      pick = slps_pkg::PAT_REPLACE;
    else if (item.battery_percent <= cfg.low_threshold_pct)
      pick = slps_pkg::PAT_LOW;
    else if (!item.half_link_up)
      pick = slps_pkg::PAT_HALF;
    else if (!item.host_link_up)
      pick = slps_pkg::PAT_HOST;
    else
      pick = slps_pkg::PAT_IDLE;
  end

  // Battery pulse position, wrapped to the pattern's edge count
  assign edges       = (pick == slps_pkg::PAT_REPLACE) ? slps_pkg::REPLACE_EDGES
                                                        : slps_pkg::LOW_EDGES;
  assign step_base   = (pick != cur.shown) ? 2'd0 : cur.step;
  assign bat_pos     = ({1'b0, step_base} >= edges) ? 3'd0 : {1'b0, step_base};
  assign bat_on      = !bat_pos[0];
  assign bat_pos_inc = bat_pos + 3'd1;
  assign blink_col   = (pick == slps_pkg::PAT_HALF) ? slps_pkg::COL_GREEN
                                                    : slps_pkg::COL_BLUE;

  // Timer and pattern update
  always_comb begin
    nxt           = cur;
    nxt.last_active = item.active;
    nxt.last_pct    = item.battery_percent;
    nxt.last_host   = item.host_link_up;
    nxt.last_half   = item.half_link_up;
    delay_nxt     = delay_cur;
    next_delay    = '0;
    next_ext      = '0;
    run           = 1'b0;

    if (!item.active) begin
      nxt.color = slps_pkg::COL_OFF;
    end else begin
      if (force_step || delay_cur == '0) begin
        run = 1'b1;
      end else begin
        delay_nxt = delay_dec;
        run       = (delay_dec == '0);
      end

      if (run) begin
        nxt.shown = pick;
        nxt.step  = step_base;
        case (pick)
          slps_pkg::PAT_BOOT: begin
            nxt.color = slps_pkg::COL_BLUE;
            if (step_base == 2'd0) begin
              nxt.step   = 2'd1;
              next_delay = slps_pkg::DELAY_W'(cfg.boot_solid_ms);
            end else begin
              nxt.boot_pending = 1'b0;
            end
          end
          slps_pkg::PAT_HALF, slps_pkg::PAT_HOST: begin
            nxt.step   = step_base ^ 2'd1;
            nxt.color  = nxt.step[0] ? blink_col : slps_pkg::COL_OFF;
            next_delay = slps_pkg::DELAY_W'(cfg.blink_half_ms);
          end
          slps_pkg::PAT_REPLACE, slps_pkg::PAT_LOW: begin
            nxt.color = bat_on ? slps_pkg::COL_AMBER : slps_pkg::COL_OFF;
            if (bat_pos_inc >= edges) begin
              nxt.step   = 2'd0;
              next_delay = (pick == slps_pkg::PAT_REPLACE)
                           ? slps_pkg::DELAY_W'(cfg.replace_rest_ms)
                           : slps_pkg::DELAY_W'(cfg.low_rest_ms);
            end else begin
              nxt.step   = bat_pos_inc[1:0];
              next_delay = bat_on ? slps_pkg::DELAY_W'(cfg.amber_on_ms)
                                  : slps_pkg::DELAY_W'(cfg.amber_gap_ms);
            end
          end
          default: begin
            // idle: dark, recheck after four fast periods
            nxt.color  = slps_pkg::COL_OFF;
            next_delay = {cfg.blink_half_ms, 2'b00};
          end
        endcase
        // saturate to the timer range
        next_ext  = CMP_W'(next_delay);
        delay_nxt = (next_ext > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                           : next_ext[TIMER_BITS-1:0];
      end
    end
  end

  // LED drive from the updated color
  assign result.led_red       = (nxt.color == slps_pkg::COL_AMBER);
  assign result.led_green     = (nxt.color == slps_pkg::COL_AMBER) ||
                                (nxt.color == slps_pkg::COL_GREEN);
  assign result.led_blue      = (nxt.color == slps_pkg::COL_BLUE);
  assign result.shown_pattern = nxt.shown;

endmodule

/* hw/rtl/status_led_pattern_sequencer.sv */
// Top level of the status LED pattern sequencer: input register, step logic,
// state and result registers. Depends on slps_pkg, slps_stream_if,
// slps_cfg_regs and slps_step_logic.
//
//   channel  | dir | payload                                         | transfer when
//   ---------+-----+-------------------------------------------------+--------------
//   in_ch    | in  | active, battery_percent, host/half link up      | valid & ready
//   out_ch   | out | led_red, led_green, led_blue, shown_pattern     | valid & ready
//   cfg_ch   | in  | index (3 bits), data (16 bits)                  | valid & ready
//
// One tick per clock sustained while out_ch is not stalled; a result passes the
// input register, then the state and result registers, before it is offered
// on out_ch.
// The state update is a single pass of the step logic between those registers.
// Reset (rst_n low, synchronous) loads register defaults and the power-on state.
// A stalled result holds the input register; in_ch.ready drops only when both
// the input register and the result register are full and out_ch is stalled.
// cfg_ch.ready is always high.
`timescale 1ns / 1ps

module status_led_pattern_sequencer #(
  parameter int TIMER_BITS = slps_pkg::TIMER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  slps_stream_if.sink   in_ch,
  slps_stream_if.source out_ch,
  slps_stream_if.sink   cfg_ch
);

  slps_pkg::cfg_t         cfg;
  slps_pkg::in_payload_t  item_r;
  logic                   item_valid_r;
  slps_pkg::seq_state_t   state_r;
  slps_pkg::seq_state_t   state_nxt;
  logic [TIMER_BITS-1:0]  delay_r;
  logic [TIMER_BITS-1:0]  delay_nxt;
  slps_pkg::out_payload_t result;
  slps_pkg::out_payload_t out_data_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   in_xfer;

  slps_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  slps_step_logic #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step_logic (
    .cfg       (cfg),
    .item      (item_r),
    .cur       (state_r),
    .delay_cur (delay_r),
    .nxt       (state_nxt),
    .delay_nxt (delay_nxt),
    .result    (result)
  );

  // Handshake: the held tick moves on when the result register is empty or being taken
  assign advance      = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !item_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_data_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_xfer) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_ch.payload;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.shown        <= slps_pkg::PAT_IDLE;
      state_r.step         <= 2'd0;
      state_r.boot_pending <= 1'b1;
      state_r.color        <= slps_pkg::COL_OFF;
      state_r.last_active  <= 1'b1;
      state_r.last_pct     <= slps_pkg::LAST_PCT_RST;
      state_r.last_host    <= 1'b0;
      state_r.last_half    <= 1'b1;
      delay_r              <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      delay_r <= delay_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule

/* tb/slps_led_checker.sv */
// Checker for the status LED pattern sequencer: watches the input, result and
// configuration channels, predicts each result per tick and compares it.
// Depends on slps_pkg only.
`timescale 1ns / 1ps

module slps_led_checker
  import slps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  in_payload_t  in_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  out_payload_t out_data,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  cfg_payload_t cfg_data,
  output int           error_count,
  output int           pending_count
);

  localparam int TIMER_BITS = TIMER_BITS_DEF;
  localparam logic [DELAY_W-1:0] TIMER_MAX = DELAY_W'((1 << TIMER_BITS) - 1);

  // Predicted register file and sequencer state
  cfg_t                  regs;
  pattern_t              shown;
  logic [1:0]            step;
  logic                  boot_pending;
  color_t                color;
  logic [TIMER_BITS-1:0] delay_left;
  logic                  last_active;
  logic [PCT_W-1:0]      last_pct;
  logic                  last_host;
  logic                  last_half;

  out_payload_t expected_leds[$];

  // Priority: boot, replace, low, half lost, host lost, idle
  function automatic pattern_t choose_pattern(logic [PCT_W-1:0] pct, logic host,
                                              logic half);
    if (boot_pending) return PAT_BOOT;
    if (pct <= regs.replace_threshold_pct) return PAT_REPLACE;
    if (pct <= regs.low_threshold_pct) return PAT_LOW;
    if (!half) return PAT_HALF;
    if (!host) return PAT_HOST;
    return PAT_IDLE;
  endfunction

  // One pattern step; reloads the delay timer
  function automatic void step_pattern(logic [PCT_W-1:0] pct, logic host, logic half);
    pattern_t           st;
    color_t             blink;
    logic [DELAY_W-1:0] hold_ms;
    int                 edges;
    int                 s;
    logic               on;
    st = choose_pattern(pct, host, half);
    hold_ms = '0;
    if (st != shown) begin
      shown = st;
      step = 2'd0;
    end
    case (st)
      PAT_BOOT: begin
        color = COL_BLUE;
        if (step == 2'd0) begin
          step = 2'd1;
          hold_ms = DELAY_W'(regs.boot_solid_ms);
        end else begin
          boot_pending = 1'b0;
          hold_ms = '0;
        end
      end
      PAT_HALF, PAT_HOST: begin
        blink = (st == PAT_HALF) ? COL_GREEN : COL_BLUE;
        step = step ^ 2'd1;
        color = step[0] ? blink : COL_OFF;
        hold_ms = DELAY_W'(regs.blink_half_ms);
      end
      PAT_REPLACE, PAT_LOW: begin
        edges = (st == PAT_REPLACE) ? 4 : 2;
        s = int'(step);
        if (s >= edges) s = 0;
        on = (s[0] == 1'b0);
        color = on ? COL_AMBER : COL_OFF;
        s++;
        if (s >= edges) begin
          step = 2'd0;
          hold_ms = (st == PAT_REPLACE) ? DELAY_W'(regs.replace_rest_ms)
                                        : DELAY_W'(regs.low_rest_ms);
        end else begin
          step = s[1:0];
          hold_ms = on ? DELAY_W'(regs.amber_on_ms) : DELAY_W'(regs.amber_gap_ms);
        end
      end
      default: begin
        // idle recheck at four fast periods
        color = COL_OFF;
        hold_ms = {regs.blink_half_ms, 2'b00};
      end
    endcase
    delay_left = (hold_ms > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                       : hold_ms[TIMER_BITS-1:0];
  endfunction

  // One millisecond tick: update state, return the LED drive
  function automatic out_payload_t take_tick(in_payload_t it);
    out_payload_t r;
    logic         changed;
    logic         run;
    changed = (it.battery_percent != last_pct) || (it.host_link_up != last_host) ||
              (it.half_link_up != last_half);
    if (!it.active) begin
      color = COL_OFF;
    end else begin
      run = !last_active || (changed && !boot_pending) || (delay_left == '0);
      if (!run) begin
        delay_left = delay_left - TIMER_BITS'(1);
        run = (delay_left == '0);
      end
      if (run) step_pattern(it.battery_percent, it.host_link_up, it.half_link_up);
    end
    last_active = it.active;
    last_pct    = it.battery_percent;
    last_host   = it.host_link_up;
    last_half   = it.half_link_up;
    r.led_red       = (color == COL_AMBER);
    r.led_green     = (color == COL_AMBER) || (color == COL_GREEN);
    r.led_blue      = (color == COL_BLUE);
    r.shown_pattern = shown;
    return r;
  endfunction

  always @(posedge clk) begin
    out_payload_t want;
    if (!rst_n) begin
      regs.boot_solid_ms         <= BOOT_ON_RST;
      regs.blink_half_ms         <= FAST_BLINK_RST;
      regs.amber_on_ms           <= PULSE_RST;
      regs.amber_gap_ms          <= PULSE_GAP_RST;
      regs.low_rest_ms           <= LOW_REST_RST;
      regs.replace_rest_ms       <= REPLACE_REST_RST;
      regs.low_threshold_pct     <= LOW_THR_RST;
      regs.replace_threshold_pct <= REPLACE_THR_RST;
      shown        = PAT_IDLE;
      step         = 2'd0;
      boot_pending = 1'b1;
      color        = COL_OFF;
      delay_left   = '0;
      last_active  = 1'b1;
      last_pct     = LAST_PCT_RST;
      last_host    = 1'b0;
      last_half    = 1'b1;
      expected_leds.delete();
      error_count   <= 0;
      pending_count <= 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_leds.size() == 0) begin
          $display("%0t: unexpected result r=%b g=%b b=%b pat=%0d", $time,
                   out_data.led_red, out_data.led_green, out_data.led_blue,
                   out_data.shown_pattern);
          error_count <= error_count + 1;
        end else begin
          want = expected_leds.pop_front();
          if (out_data.led_red !== want.led_red || out_data.led_green !== want.led_green ||
              out_data.led_blue !== want.led_blue ||
              out_data.shown_pattern !== want.shown_pattern) begin
            $display("%0t: mismatch expected r=%b g=%b b=%b pat=%0d, got r=%b g=%b b=%b pat=%0d",
                     $time, want.led_red, want.led_green, want.led_blue, want.shown_pattern,
                     out_data.led_red, out_data.led_green, out_data.led_blue,
                     out_data.shown_pattern);
            error_count <= error_count + 1;
          end
        end
      end
      // input transfer: predict
      if (in_valid && in_ready) expected_leds.push_back(take_tick(in_data));
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_BOOT_ON:      regs.boot_solid_ms         <= cfg_data.data;
          REG_FAST_BLINK:   regs.blink_half_ms         <= cfg_data.data;
          REG_PULSE:        regs.amber_on_ms           <= cfg_data.data;
          REG_PULSE_GAP:    regs.amber_gap_ms          <= cfg_data.data;
          REG_LOW_REST:     regs.low_rest_ms           <= cfg_data.data;
          REG_REPLACE_REST: regs.replace_rest_ms       <= cfg_data.data;
          REG_LOW_THR:      regs.low_threshold_pct     <= cfg_data.data[PCT_W-1:0];
          REG_REPLACE_THR:  regs.replace_threshold_pct <= cfg_data.data[PCT_W-1:0];
          default: ;
        endcase
      end
      pending_count <= expected_leds.size();
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top for the status LED pattern sequencer: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on slps_pkg, slps_stream_if,
// slps_led_checker and the sequencer RTL.
`timescale 1ns / 1ps

module tb;
  import slps_pkg::*;

  localparam int ITEMS_PER_PHASE = 112;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_CYCLES     = 150;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic clk;
  logic rst_n;

  slps_stream_if #(.payload_t(in_payload_t))  in_ch();
  slps_stream_if #(.payload_t(out_payload_t)) out_ch();
  slps_stream_if #(.payload_t(cfg_payload_t)) cfg_ch();

  int errors;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_served;
  int quiet_cycles;
  logic [PCT_W-1:0] low_thr;
  logic [PCT_W-1:0] rep_thr;

  status_led_pattern_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  slps_led_checker led_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.payload),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.payload),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_data      (cfg_ch.payload),
    .error_count   (errors),
    .pending_count (pending)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_served < hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One tick transfer with random sender gaps
  task automatic send_item(input in_payload_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_status(input logic act, input logic [PCT_W-1:0] pct,
                             input logic host, input logic half);
    in_payload_t it;
    it.active          = act;
    it.battery_percent = pct;
    it.host_link_up    = host;
    it.half_link_up    = half;
    send_item(it);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [MS_W-1:0] value);
    cfg_payload_t w;
    w.index = idx;
    w.data  = value;
    @(negedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write all eight registers; thresholds carry junk in the unused upper bits
  task automatic program_regs(input logic [MS_W-1:0] boot_v, fast_v, pulse_v, gap_v,
                              low_rest_v, rep_rest_v,
                              input logic [PCT_W-1:0] low_thr_v, rep_thr_v);
    logic [MS_W-PCT_W-1:0] junk;
    write_reg(REG_BOOT_ON, boot_v);
    write_reg(REG_FAST_BLINK, fast_v);
    write_reg(REG_PULSE, pulse_v);
    write_reg(REG_PULSE_GAP, gap_v);
    write_reg(REG_LOW_REST, low_rest_v);
    write_reg(REG_REPLACE_REST, rep_rest_v);
    junk = (MS_W-PCT_W)'($urandom);
    write_reg(REG_LOW_THR, {junk, low_thr_v});
    junk = (MS_W-PCT_W)'($urandom);
    write_reg(REG_REPLACE_THR, {junk, rep_thr_v});
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    low_thr = low_thr_v;
    rep_thr = rep_thr_v;
  endtask

  // Mostly short timing values so patterns cycle within a status run
  function automatic logic [MS_W-1:0] rand_ms();
    if ($urandom_range(9) < 8) return MS_W'($urandom_range(0, 12));
    return MS_W'($urandom_range(13, 400));
  endfunction

  function automatic logic [PCT_W-1:0] rand_pct();
    int t;
    case ($urandom_range(2))
      0: t = $urandom_range(0, 127);
      1: t = int'($urandom_range(1) ? low_thr : rep_thr) + int'($urandom_range(0, 2)) - 1;
      default: t = $urandom_range(90, 127);
    endcase
    if (t < 0) t = 0;
    if (t > 127) t = 127;
    return PCT_W'(t);
  endfunction

  // Runs of constant status so timers expire, with some noise inside a run
  task automatic run_random_phase(input int count);
    in_payload_t base;
    in_payload_t it;
    int          sent;
    int          run_len;
    sent = 0;
    while (sent < count) begin
      base.active          = ($urandom_range(99) < 90);
      base.battery_percent = rand_pct();
      base.host_link_up    = ($urandom_range(99) < 60);
      base.half_link_up    = ($urandom_range(99) < 60);
      run_len = $urandom_range(1, 24);
      for (int k = 0; k < run_len && sent < count; k++) begin
        it = base;
        case ($urandom_range(19))
          0: it.active = ~it.active;
          1: it.battery_percent = PCT_W'($urandom_range(0, 127));
          2: it.host_link_up = ~it.host_link_up;
          3: it.half_link_up = ~it.half_link_up;
          default: ;
        endcase
        send_item(it);
        sent++;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    low_thr        = LOW_THR_RST;
    rep_thr        = REPLACE_THR_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: boot, inactive during boot, every pattern, threshold edges
    program_regs(16'd2, 16'd2, 16'd1, 16'd2, 16'd4, 16'd3, 7'd15, 7'd5);
    send_status(1'b1, 7'd100, 1'b1, 1'b1);
    send_status(1'b0, 7'd0, 1'b0, 1'b0);
    send_status(1'b1, 7'd100, 1'b1, 1'b1);
    send_status(1'b1, 7'd100, 1'b1, 1'b1);
    send_status(1'b1, 7'd0, 1'b1, 1'b1);
    repeat (3) send_status(1'b1, 7'd0, 1'b1, 1'b1);
    send_status(1'b1, 7'd127, 1'b1, 1'b1);
    repeat (2) send_status(1'b1, 7'd10, 1'b1, 1'b1);
    repeat (3) send_status(1'b1, 7'd50, 1'b1, 1'b0);
    repeat (2) send_status(1'b1, 7'd50, 1'b0, 1'b1);
    send_status(1'b1, 7'd50, 1'b0, 1'b0);
    send_status(1'b1, 7'd5, 1'b0, 1'b0);
    send_status(1'b1, 7'd6, 1'b1, 1'b1);
    send_status(1'b1, 7'd15, 1'b1, 1'b1);
    send_status(1'b1, 7'd16, 1'b1, 1'b1);
    repeat (2) send_status(1'b0, 7'd16, 1'b1, 1'b1);
    send_status(1'b1, 7'd16, 1'b1, 1'b1);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_drained();

    // Random phases, each with its own register setting and one of four idling modes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd100, 7'd0);
        1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        7'd0, 7'd100);
        5: program_regs(rand_ms(), MS_W'($urandom_range(16384, 65535)), rand_ms(),
                        rand_ms(), rand_ms(), rand_ms(),
                        PCT_W'($urandom_range(0, 127)), PCT_W'($urandom_range(0, 127)));
        default: program_regs(rand_ms(), rand_ms(), rand_ms(), rand_ms(), rand_ms(),
                              rand_ms(), PCT_W'($urandom_range(0, 127)),
                              PCT_W'($urandom_range(0, 127)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 4) hold_req++;
      run_random_phase(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/slps_pkg.sv
hw/rtl/slps_stream_if.sv
hw/rtl/slps_cfg_regs.sv
hw/rtl/slps_step_logic.sv
hw/rtl/status_led_pattern_sequencer.sv
tb/slps_led_checker.sv
tb/tb.sv
